// ----- src/gb3_pkg.sv -----
// Shared constants, types and helpers for the 3x3 Gaussian blur core.
package gb3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 12;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SUM_W   = PIX_W + 4;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

    // One classified pixel handed from the front end to the window datapath
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] above1;
        logic [PIX_W-1:0] above2;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } gb3_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] res;
        if (v < DIM_MIN)
        begin
            res = DIM_MIN;
        end
        else if (v > maxv)
        begin
            res = maxv;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- src/gb3_front.sv -----
// Front end: position counters, two line buffers and classification of each pixel.
module gb3_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gb3_pkg::DIM_W-1:0]     image_width,
    input  logic [gb3_pkg::DIM_W-1:0]     image_height,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  logic [gb3_pkg::PIX_W-1:0]     pix,
    input  logic [gb3_pkg::QCNT_W-1:0]    queue_count,
    output logic                          push,
    output gb3_pkg::gb3_item_t            push_item
);

    logic [gb3_pkg::DIM_W-1:0] w_eff;
    logic [gb3_pkg::DIM_W-1:0] h_eff;
    logic [gb3_pkg::COL_W-1:0] col_count_reg;
    logic [gb3_pkg::ROW_W-1:0] row_count_reg;
    logic [gb3_pkg::COL_W-1:0] col_cur;
    logic [gb3_pkg::ROW_W-1:0] row_cur;
    logic [gb3_pkg::DIM_W-1:0] col_inc;
    logic [gb3_pkg::DIM_W-1:0] row_inc;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      accept;
    logic                      emit;
    logic                      last;
    logic [gb3_pkg::QCNT_W:0]  occupancy;

    logic                      f1_valid_reg;
    logic [gb3_pkg::PIX_W-1:0] f1_pix_reg;
    logic [gb3_pkg::COL_W-1:0] f1_col_reg;
    logic [gb3_pkg::ROW_W-1:0] f1_row_reg;
    logic                      f1_emit_reg;
    logic                      f1_last_reg;
    logic [gb3_pkg::PIX_W-1:0] rd1_reg;
    logic [gb3_pkg::PIX_W-1:0] rd2_reg;

    // line1: previous row, line2: the row before it
    logic [gb3_pkg::PIX_W-1:0] line1_mem [gb3_pkg::MAX_WIDTH];
    logic [gb3_pkg::PIX_W-1:0] line2_mem [gb3_pkg::MAX_WIDTH];

    always_comb
    begin
        w_eff = gb3_pkg::clamp_dim(image_width, gb3_pkg::DIM_W'(gb3_pkg::MAX_WIDTH));
        h_eff = gb3_pkg::clamp_dim(image_height, gb3_pkg::DIM_W'(gb3_pkg::MAX_HEIGHT));
        // a counter left beyond a shrunken geometry restarts at zero
        col_cur = ({1'b0, col_count_reg} >= w_eff) ? '0 : col_count_reg;
        row_cur = ({1'b0, row_count_reg} >= h_eff) ? '0 : row_count_reg;
        col_inc = {1'b0, col_cur} + gb3_pkg::DIM_W'(1);
        row_inc = {1'b0, row_cur} + gb3_pkg::DIM_W'(1);
        col_wrap = col_inc >= w_eff;
        row_wrap = row_inc >= h_eff;
        emit = (row_cur >= gb3_pkg::ROW_W'(2)) && (col_cur >= gb3_pkg::COL_W'(2));
        last = (col_inc == w_eff) && (row_inc == h_eff);
        // the stage behind the read never stalls, so hold room for it in the queue
        occupancy = {1'b0, queue_count} + (gb3_pkg::QCNT_W + 1)'(f1_valid_reg);
        pix_ready = occupancy < (gb3_pkg::QCNT_W + 1)'(gb3_pkg::QUEUE_DEPTH);
        accept = pix_valid && pix_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            f1_valid_reg  <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            if (accept)
            begin
                if (col_wrap)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= row_wrap ? '0 : row_inc[gb3_pkg::ROW_W-1:0];
                end
                else
                begin
                    col_count_reg <= col_inc[gb3_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_pix_reg  <= pix;
            f1_col_reg  <= col_cur;
            f1_row_reg  <= row_cur;
            f1_emit_reg <= emit;
            f1_last_reg <= last;
        end
    end

    // Read at accept, write back from the f1 registers in the next cycle; width >= 3 keeps the same
    // column from being read again before its write lands.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd1_reg <= line1_mem[col_cur];
            rd2_reg <= line2_mem[col_cur];
        end
        if (f1_valid_reg)
        begin
            line1_mem[f1_col_reg] <= f1_pix_reg;
            line2_mem[f1_col_reg] <= rd1_reg;
        end
    end

    always_comb
    begin
        push             = f1_valid_reg;
        push_item.pix    = f1_pix_reg;
        push_item.above1 = rd1_reg;
        push_item.above2 = rd2_reg;
        push_item.emit   = f1_emit_reg;
        push_item.last   = f1_last_reg;
        push_item.col    = f1_col_reg - gb3_pkg::COL_W'(1);
        push_item.row    = f1_row_reg - gb3_pkg::ROW_W'(1);
    end

endmodule

// ----- src/gb3_queue.sv -----
// Short queue that decouples the front end from the window datapath.
module gb3_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  gb3_pkg::gb3_item_t         push_item,
    input  logic                       pop,
    output logic                       not_empty,
    output gb3_pkg::gb3_item_t         head,
    output logic [gb3_pkg::QCNT_W-1:0] count
);

    gb3_pkg::gb3_item_t          slot_reg [gb3_pkg::QUEUE_DEPTH];
    logic [gb3_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [gb3_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [gb3_pkg::QCNT_W-1:0]  count_reg;
    logic [gb3_pkg::QCNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + gb3_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - gb3_pkg::QCNT_W'(1);
        end
        not_empty = count_reg != '0;
        head      = slot_reg[rd_ptr_reg];
        count     = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + gb3_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + gb3_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/gb3_back.sv -----
// Back end: 3x3 window shift, Gaussian weighting and the output register.
module gb3_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          not_empty,
    input  gb3_pkg::gb3_item_t            head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gb3_pkg::OUT_W-1:0]     out_data,
    output logic                          out_last
);

    // [0..2]: column c-2, rows r-2..r; [3..5]: column c-1
    logic [gb3_pkg::PIX_W-1:0] win_reg [6];
    logic [gb3_pkg::SUM_W-1:0] sum;
    logic                      out_valid_reg;
    logic [gb3_pkg::PIX_W-1:0] blurred_reg;
    logic [gb3_pkg::COL_W-1:0] col_reg;
    logic [gb3_pkg::ROW_W-1:0] row_reg;
    logic                      last_reg;

    always_comb
    begin
        pop = not_empty && (!out_valid_reg || out_ready);
        sum = gb3_pkg::SUM_W'(win_reg[0])
            + (gb3_pkg::SUM_W'(win_reg[3]) << 1)
            + gb3_pkg::SUM_W'(head.above2)
            + (gb3_pkg::SUM_W'(win_reg[1]) << 1)
            + (gb3_pkg::SUM_W'(win_reg[4]) << 2)
            + (gb3_pkg::SUM_W'(head.above1) << 1)
            + gb3_pkg::SUM_W'(win_reg[2])
            + (gb3_pkg::SUM_W'(win_reg[5]) << 1)
            + gb3_pkg::SUM_W'(head.pix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= head.above2;
                win_reg[4] <= head.above1;
                win_reg[5] <= head.pix;
                out_valid_reg <= head.emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.emit)
        begin
            blurred_reg <= sum[gb3_pkg::SUM_W-1:4];
            col_reg     <= head.col;
            row_reg     <= head.row;
            last_reg    <= head.last;
        end
    end

    always_comb
    begin
        out_valid = out_valid_reg;
        out_data  = gb3_pkg::OUT_W'({row_reg, col_reg, blurred_reg});
        out_last  = last_reg;
    end

endmodule

// ----- src/gaussian_blur_3x3_core.sv -----
// Top level of the 3x3 Gaussian blur core.
// Gray pixels stream in raster order, one beat per pixel, and the core takes one pixel
// every clock in steady state unless the output stalls. Each interior pixel yields one
// beat with its blurred value (mask 1,2,1/2,4,2/1,2,1, sum divided by 16) and its column
// and row once the pixel that completes its window has passed the front-end register,
// the queue and the output register; border pixels yield nothing. The rate is set by the
// two line-buffer memories, each read once and written once per pixel over a two-stage
// front end, and by a four-entry queue ahead of the window datapath. image_width and
// image_height are clamped to 3..2048 and must only be written while the core is idle.
module gaussian_blur_3x3_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gb3_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gb3_pkg::OUT_W-1:0]         m_axis_tdata,   // [7:0] blurred, [18:8] out_col,
                                                              // [29:19] out_row, [31:30] zero
    output logic                              m_axis_tlast,   // last_of_frame
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gb3_pkg::DIM_W-1:0]         cfg_data
);

    logic [gb3_pkg::DIM_W-1:0]  width_reg;
    logic [gb3_pkg::DIM_W-1:0]  height_reg;
    logic                       push;
    gb3_pkg::gb3_item_t         push_item;
    logic                       pop;
    logic                       not_empty;
    gb3_pkg::gb3_item_t         head;
    logic [gb3_pkg::QCNT_W-1:0] queue_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gb3_pkg::WIDTH_RESET;
            height_reg <= gb3_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                gb3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    gb3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix_valid    (s_axis_tvalid),
        .pix_ready    (s_axis_tready),
        .pix          (s_axis_tdata),
        .queue_count  (queue_count),
        .push         (push),
        .push_item    (push_item)
    );

    gb3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .count     (queue_count)
    );

    gb3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- src/gb3_checker.sv -----
// Port-level checks for the 3x3 Gaussian blur core, bound to the top level.
module gb3_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [gb3_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          m_axis_tlast
);

    // a stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // a stalled result beat is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // results only exist for interior pixels, padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:8] != 11'd0) && (m_axis_tdata[29:19] != 11'd0)
                          && (m_axis_tdata[31:30] == 2'd0))
        else $error("result for a border pixel");

    // nothing leaves in the first cycle out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result beat straight out of reset");

endmodule

bind gaussian_blur_3x3_core gb3_checker u_gb3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
